### rtl/assert_macros.svh
// Assertion helpers; clk and rst_n must be visible where these are used.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`define GGM_ASSERT(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error(msg);

`define GGM_ASSERT_NEVER(label, expr, msg) \
    `GGM_ASSERT(label, !(expr), msg)

`endif

### rtl/ggm_pkg.sv
package ggm_pkg;

    // window ROM geometry
    localparam int WIN_SIZE = 1024;
    localparam int WIN_AW   = 10;

    localparam int CFG_W = 17;
    localparam logic [15:0] GAIN_RESET = 16'd4096;

    localparam logic [63:0] WIN_N   = 64'(WIN_SIZE);
    localparam logic [63:0] ONE_Q30 = 64'd1 << 30;
    localparam logic [63:0] HALF_Q30 = 64'd1 << 29;
    localparam logic [63:0] PI_Q30  = 64'd3373259426;

    typedef enum logic [1:0] {
        CMD_LOAD  = 2'd0,
        CMD_SPAWN = 2'd1,
        CMD_TICK  = 2'd2
    } cmd_e;

    typedef enum logic [1:0] {
        REG_WINDOW_SHAPE  = 2'd0,
        REG_SAMPLE_COUNT  = 2'd1,
        REG_STEREO_SOURCE = 2'd2,
        REG_OUTPUT_GAIN   = 2'd3
    } reg_e;

    typedef struct packed {
        logic [31:0] start;
        logic [19:0] len;
        logic [19:0] offset;
        logic [15:0] rate;
        logic        backwards;
        logic [15:0] amp;
        logic [15:0] pan_l;
        logic [15:0] pan_r;
    } slot_t;

    typedef struct packed {
        logic accept;
        logic slot_clr;
        logic slot_inc;
        logic slot_rd;
        logic spawn_wr;
        logic grain_end;
        logic calc_prod;
        logic calc_idx;
        logic st_rd1;
        logic st_rd2;
        logic interp;
        logic amp_mul;
        logic div_start;
        logic rom_rd;
        logic win_mul;
        logic pan_mul;
        logic acc_clr;
        logic acc_wb;
        logic fin_mul;
        logic fin_out;
    } ctl_cmd_t;

    typedef struct packed {
        logic cnt_zero;
        logic slot_active;
        logic last_slot;
        logic grain_done;
        logic out_range;
        logic div_done;
        logic out_free;
    } dp_stat_t;

    function automatic logic [63:0] sin_q30(input logic [63:0] x);
        logic [63:0] x2;
        logic [63:0] term;
        longint      sum;
        x2   = (x * x) >> 30;
        term = x;
        sum  = longint'(x);
        term = ((term * x2) >> 30) / 64'd6;   sum = sum - longint'(term);
        term = ((term * x2) >> 30) / 64'd20;  sum = sum + longint'(term);
        term = ((term * x2) >> 30) / 64'd42;  sum = sum - longint'(term);
        term = ((term * x2) >> 30) / 64'd72;  sum = sum + longint'(term);
        term = ((term * x2) >> 30) / 64'd110; sum = sum - longint'(term);
        term = ((term * x2) >> 30) / 64'd156; sum = sum + longint'(term);
        term = ((term * x2) >> 30) / 64'd210; sum = sum - longint'(term);
        if (sum < 0)
            sum = 0;
        if (sum > longint'(ONE_Q30))
            sum = longint'(ONE_Q30);
        return 64'(sum);
    endfunction

    function automatic logic [63:0] exp_neg_q30(input logic [63:0] z);
        logic [63:0] term;
        logic [63:0] e;
        longint      sum;
        term = ONE_Q30;
        sum  = longint'(ONE_Q30);
        term = (term * z) >> 30;                sum = sum - longint'(term);
        term = ((term * z) >> 30) / 64'd2;      sum = sum + longint'(term);
        term = ((term * z) >> 30) / 64'd3;      sum = sum - longint'(term);
        term = ((term * z) >> 30) / 64'd4;      sum = sum + longint'(term);
        term = ((term * z) >> 30) / 64'd5;      sum = sum - longint'(term);
        term = ((term * z) >> 30) / 64'd6;      sum = sum + longint'(term);
        term = ((term * z) >> 30) / 64'd7;      sum = sum - longint'(term);
        term = ((term * z) >> 30) / 64'd8;      sum = sum + longint'(term);
        term = ((term * z) >> 30) / 64'd9;      sum = sum - longint'(term);
        term = ((term * z) >> 30) / 64'd10;     sum = sum + longint'(term);
        if (sum < 0)
            sum = 0;
        if (sum > longint'(ONE_Q30))
            sum = longint'(ONE_Q30);
        e = 64'(sum);
        // e^(-z) squared three times, giving e^(-8z)
        e = (e * e + HALF_Q30) >> 30;
        e = (e * e + HALF_Q30) >> 30;
        e = (e * e + HALF_Q30) >> 30;
        return e;
    endfunction

    function automatic logic [15:0] q30_to_q15(input logic [63:0] v);
        logic [63:0] r;
        r = (v + (64'd1 << 14)) >> 15;
        if (r > 64'd32768)
            r = 64'd32768;
        return r[15:0];
    endfunction

    function automatic logic [15:0] win_entry(input logic [1:0] shape, input logic [63:0] k);
        logic [63:0] k2;
        logic [63:0] d;
        logic [63:0] kr;
        logic [63:0] s;
        logic [63:0] z;
        logic [63:0] tri_v;
        logic [15:0] res;
        k2    = 64'd2 * k;
        d     = (k2 >= WIN_N) ? k2 - WIN_N : WIN_N - k2;
        kr    = (k <= WIN_N - k) ? k : WIN_N - k;
        s     = sin_q30((PI_Q30 * kr) / WIN_N);
        z     = ((64'd9 * d * d) << 26) / (WIN_N * WIN_N);
        tri_v = ((WIN_N - d) * 64'd32768 + WIN_N / 64'd2) / WIN_N;
        case (shape)
            2'd0:    res = q30_to_q15(s);
            2'd1:    res = q30_to_q15((s * s + HALF_Q30) >> 30);
            2'd2:    res = q30_to_q15(exp_neg_q30(z));
            default: res = tri_v[15:0];
        endcase
        return res;
    endfunction

endpackage

### rtl/ggm_ifc.sv
interface ggm_item_if;
    logic               valid;
    logic               ready;
    logic [1:0]         command;
    logic [15:0]        sample_address;
    logic signed [15:0] sample_left;
    logic signed [15:0] sample_right;
    logic [31:0]        grain_start;
    logic [19:0]        grain_length;
    logic [15:0]        grain_pitch;
    logic               grain_reverse;
    logic [15:0]        grain_amplitude;
    logic [15:0]        pan_left_gain;
    logic [15:0]        pan_right_gain;

    modport source (
        output valid, command, sample_address, sample_left, sample_right, grain_start,
               grain_length, grain_pitch, grain_reverse, grain_amplitude,
               pan_left_gain, pan_right_gain,
        input  ready
    );
    modport sink (
        input  valid, command, sample_address, sample_left, sample_right, grain_start,
               grain_length, grain_pitch, grain_reverse, grain_amplitude,
               pan_left_gain, pan_right_gain,
        output ready
    );
endinterface

interface ggm_result_if;
    logic               valid;
    logic               ready;
    logic signed [23:0] mix_left;
    logic signed [23:0] mix_right;
    logic               clipped;
    logic [8:0]         active_grains;

    modport source (
        output valid, mix_left, mix_right, clipped, active_grains,
        input  ready
    );
    modport sink (
        input  valid, mix_left, mix_right, clipped, active_grains,
        output ready
    );
endinterface

### rtl/ggm_win_rom.sv
module ggm_win_rom (
    input  logic                         clk,
    input  logic                         rd,
    input  logic [ggm_pkg::WIN_AW+1:0]   addr,
    output logic [15:0]                  data
);

    localparam int DEPTH = 4 * ggm_pkg::WIN_SIZE;

    logic [15:0] rom_tab [DEPTH];
    logic [15:0] data_reg;

    for (genvar i = 0; i < DEPTH; i++)
    begin : g_entry
        localparam logic [15:0] ENTRY =
            ggm_pkg::win_entry(2'(i / ggm_pkg::WIN_SIZE), 64'(i % ggm_pkg::WIN_SIZE));
        assign rom_tab[i] = ENTRY;
    end

    always_ff @(posedge clk)
    begin
        if (rd)
        begin
            data_reg <= rom_tab[addr];
        end
    end

    assign data = data_reg;

endmodule

### rtl/ggm_datapath.sv
module ggm_datapath #(
    parameter int GRAIN_SLOTS = 256,
    parameter int STORE_DEPTH = 65536
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  ggm_pkg::ctl_cmd_t           cmd,
    output ggm_pkg::dp_stat_t           stat,
    input  logic [1:0]                  command,
    input  logic [15:0]                 sample_address,
    input  logic signed [15:0]          sample_left,
    input  logic signed [15:0]          sample_right,
    input  logic [31:0]                 grain_start,
    input  logic [19:0]                 grain_length,
    input  logic [15:0]                 grain_pitch,
    input  logic                        grain_reverse,
    input  logic [15:0]                 grain_amplitude,
    input  logic [15:0]                 pan_left_gain,
    input  logic [15:0]                 pan_right_gain,
    input  logic                        cfg_we,
    input  logic [1:0]                  cfg_index,
    input  logic [ggm_pkg::CFG_W-1:0]   cfg_data,
    output logic                        out_valid,
    input  logic                        out_ready,
    output logic signed [23:0]          mix_left,
    output logic signed [23:0]          mix_right,
    output logic                        clipped,
    output logic [8:0]                  active_grains
);

    localparam int SLOT_AW = (GRAIN_SLOTS > 1) ? $clog2(GRAIN_SLOTS) : 1;
    localparam int ST_AW   = $clog2(STORE_DEPTH);
    localparam int CNT_W   = $clog2(GRAIN_SLOTS + 1);
    localparam int ACC_W   = 33 + SLOT_AW;
    localparam int HI_W    = ACC_W - 20;
    localparam int TOT_W   = ACC_W + 17;
    localparam int SH_W    = TOT_W - 12;
    localparam int DC_W    = $clog2(ggm_pkg::WIN_AW + 1);
    localparam logic [20:0] DEPTH_W = 21'(STORE_DEPTH);
    localparam logic [SLOT_AW-1:0] LAST_SLOT = SLOT_AW'(GRAIN_SLOTS - 1);
    localparam logic signed [SH_W-1:0] SAT_HI = SH_W'(8388607);
    localparam logic signed [SH_W-1:0] SAT_LO = -SAT_HI - SH_W'(1);

    // configuration
    logic [1:0]  shape_reg;
    logic [16:0] sc_reg;
    logic        stereo_reg;
    logic [15:0] gain_reg;
    logic [20:0] cnt_eff;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            shape_reg  <= '0;
            sc_reg     <= '0;
            stereo_reg <= 1'b0;
            gain_reg   <= ggm_pkg::GAIN_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                ggm_pkg::REG_WINDOW_SHAPE:  shape_reg  <= cfg_data[1:0];
                ggm_pkg::REG_SAMPLE_COUNT:  sc_reg     <= cfg_data[16:0];
                ggm_pkg::REG_STEREO_SOURCE: stereo_reg <= cfg_data[0];
                ggm_pkg::REG_OUTPUT_GAIN:   gain_reg   <= cfg_data[15:0];
                default: ;
            endcase
        end
    end

    assign cnt_eff = ({4'b0, sc_reg} > DEPTH_W) ? DEPTH_W : {4'b0, sc_reg};

    // slot walk, active bits and count
    logic [SLOT_AW-1:0]     g_reg;
    logic [GRAIN_SLOTS-1:0] active_reg;
    logic [CNT_W-1:0]       count_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            g_reg      <= '0;
            active_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (cmd.slot_clr)
                g_reg <= '0;
            else if (cmd.slot_inc)
                g_reg <= g_reg + SLOT_AW'(1);
            if (cmd.spawn_wr)
            begin
                active_reg[g_reg] <= 1'b1;
                count_reg         <= count_reg + CNT_W'(1);
            end
            else if (cmd.grain_end)
            begin
                active_reg[g_reg] <= 1'b0;
                count_reg         <= count_reg - CNT_W'(1);
            end
        end
    end

    // sample store
    logic [31:0] store_mem [STORE_DEPTH];
    logic [31:0] st_rd_reg;
    logic [31:0] word_a_reg;
    logic [40:0] idx_reg;
    logic        oor_reg;
    logic        last_reg;
    logic [24:0] i1;
    logic [ST_AW-1:0] rd_addr;

    assign i1 = idx_reg[40:16];
    assign rd_addr = cmd.st_rd2 ? ST_AW'(i1 + 25'd1) : ST_AW'(i1);

    always_ff @(posedge clk)
    begin
        if (cmd.accept && command == ggm_pkg::CMD_LOAD && {5'b0, sample_address} < DEPTH_W)
        begin
            store_mem[ST_AW'(sample_address)] <= {sample_right, sample_left};
        end
        if (cmd.st_rd1 || cmd.st_rd2)
        begin
            st_rd_reg <= store_mem[rd_addr];
        end
    end

    // grain slot memory
    ggm_pkg::slot_t slot_mem [GRAIN_SLOTS];
    ggm_pkg::slot_t slot_rd_reg;
    ggm_pkg::slot_t spawn_reg;
    ggm_pkg::slot_t wb_word;

    always_comb
    begin
        wb_word        = slot_rd_reg;
        wb_word.offset = slot_rd_reg.offset + 20'd1;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            spawn_reg.start     <= grain_start;
            spawn_reg.len       <= grain_length;
            spawn_reg.offset    <= '0;
            spawn_reg.rate      <= grain_pitch;
            spawn_reg.backwards <= grain_reverse;
            spawn_reg.amp       <= grain_amplitude;
            spawn_reg.pan_l     <= pan_left_gain;
            spawn_reg.pan_r     <= pan_right_gain;
        end
        if (cmd.spawn_wr)
            slot_mem[g_reg] <= spawn_reg;
        else if (cmd.acc_wb)
            slot_mem[g_reg] <= wb_word;
        if (cmd.slot_rd)
            slot_rd_reg <= slot_mem[g_reg];
    end

    // per-grain arithmetic
    logic [35:0]        prod_reg;
    logic [19:0]        p_sel;
    logic [40:0]        idx_next;
    logic signed [33:0] vl_reg, vr_reg, vl_c, vr_c;
    logic signed [35:0] t1_reg, t1_c;
    logic signed [37:0] t2_reg, t2_c;
    logic signed [31:0] pl_reg, pr_reg, pl_c, pr_c;
    logic signed [ACC_W-1:0] accl_reg, accr_reg;
    logic [15:0]        win_data;

    assign p_sel = slot_rd_reg.backwards ? slot_rd_reg.len - slot_rd_reg.offset
                                         : slot_rd_reg.offset;
    assign idx_next = {9'b0, slot_rd_reg.start} + {1'b0, prod_reg, 4'b0};

    always_comb
    begin
        logic signed [15:0] la, lb, ra, rb;
        logic signed [16:0] fr;
        logic signed [34:0] sum;
        logic signed [33:0] m;
        logic signed [50:0] pa;
        logic signed [52:0] pw;
        logic signed [54:0] ql, qr;
        la = word_a_reg[15:0];
        lb = st_rd_reg[15:0];
        ra = word_a_reg[31:16];
        rb = st_rd_reg[31:16];
        fr = $signed({1'b0, idx_reg[15:0]});
        if (last_reg)
        begin
            vl_c = 34'(la) <<< 16;
            vr_c = 34'(ra) <<< 16;
        end
        else
        begin
            vl_c = (34'(la) <<< 16) + 34'(fr * (17'(lb) - 17'(la)));
            vr_c = (34'(ra) <<< 16) + 34'(fr * (17'(rb) - 17'(ra)));
        end
        if (!stereo_reg)
            vr_c = vl_c;
        sum  = 35'(vl_reg) + 35'(vr_reg);
        m    = sum[34:1];
        pa   = 51'(m) * 51'($signed({1'b0, slot_rd_reg.amp}));
        t1_c = pa[50:15];
        pw   = 53'(t1_reg) * 53'($signed({1'b0, win_data}));
        t2_c = pw[52:15];
        ql   = 55'(t2_reg) * 55'($signed({1'b0, slot_rd_reg.pan_l}));
        qr   = 55'(t2_reg) * 55'($signed({1'b0, slot_rd_reg.pan_r}));
        pl_c = ql[54:23];
        pr_c = qr[54:23];
    end

    always_ff @(posedge clk)
    begin
        if (cmd.calc_prod)
            prod_reg <= p_sel * slot_rd_reg.rate;
        if (cmd.calc_idx)
        begin
            idx_reg <= idx_next;
            oor_reg <= {1'b0, idx_next} >= {5'b0, cnt_eff, 16'b0};
        end
        if (cmd.st_rd1)
            last_reg <= ({1'b0, i1} + 26'd1) >= {5'b0, cnt_eff};
        if (cmd.st_rd2)
            word_a_reg <= st_rd_reg;
        if (cmd.interp)
        begin
            vl_reg <= vl_c;
            vr_reg <= vr_c;
        end
        if (cmd.amp_mul)
            t1_reg <= t1_c;
        if (cmd.win_mul)
            t2_reg <= t2_c;
        if (cmd.pan_mul)
        begin
            pl_reg <= pl_c;
            pr_reg <= pr_c;
        end
        if (cmd.acc_clr)
        begin
            accl_reg <= '0;
            accr_reg <= '0;
        end
        else if (cmd.acc_wb)
        begin
            accl_reg <= accl_reg + ACC_W'(pl_reg);
            accr_reg <= accr_reg + ACC_W'(pr_reg);
        end
    end

    // window index: offset * WIN_SIZE / len, one quotient bit a cycle
    logic [20:0]                 rem_reg;
    logic [ggm_pkg::WIN_AW-1:0]  quo_reg;
    logic [DC_W-1:0]             dcnt_reg;
    logic [20:0]                 rem_sh;

    assign rem_sh = {rem_reg[19:0], 1'b0};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            dcnt_reg <= '0;
        else if (cmd.div_start)
            dcnt_reg <= DC_W'(ggm_pkg::WIN_AW);
        else if (dcnt_reg != '0)
            dcnt_reg <= dcnt_reg - DC_W'(1);
    end

    always_ff @(posedge clk)
    begin
        if (cmd.div_start)
        begin
            rem_reg <= {1'b0, slot_rd_reg.offset};
            quo_reg <= '0;
        end
        else if (dcnt_reg != '0)
        begin
            if (rem_sh >= {1'b0, slot_rd_reg.len})
            begin
                rem_reg <= rem_sh - {1'b0, slot_rd_reg.len};
                quo_reg <= {quo_reg[ggm_pkg::WIN_AW-2:0], 1'b1};
            end
            else
            begin
                rem_reg <= rem_sh;
                quo_reg <= {quo_reg[ggm_pkg::WIN_AW-2:0], 1'b0};
            end
        end
    end

    ggm_win_rom u_rom (
        .clk  (clk),
        .rd   (cmd.rom_rd),
        .addr ({shape_reg, quo_reg}),
        .data (win_data)
    );

    // output gain, split into partial products
    logic [35:0]              plo_l_reg, plo_r_reg;
    logic signed [HI_W+16:0]  phi_l_reg, phi_r_reg;
    logic                     out_valid_reg;
    logic signed [23:0]       mix_l_reg, mix_r_reg;
    logic                     clip_reg;
    logic [8:0]               act_reg;
    logic signed [23:0]       sat_l, sat_r;
    logic                     clip_c;
    logic [8:0]               act_c;

    always_comb
    begin
        logic signed [TOT_W-1:0] tl, tr;
        logic signed [SH_W-1:0]  sl, sr;
        logic [CNT_W+8:0]        cext;
        tl = (TOT_W'(phi_l_reg) <<< 20) + $signed(TOT_W'(plo_l_reg));
        tr = (TOT_W'(phi_r_reg) <<< 20) + $signed(TOT_W'(plo_r_reg));
        sl = tl[TOT_W-1:12];
        sr = tr[TOT_W-1:12];
        clip_c = 1'b0;
        if (sl > SAT_HI)
        begin
            sat_l  = 24'sh7FFFFF;
            clip_c = 1'b1;
        end
        else if (sl < SAT_LO)
        begin
            sat_l  = 24'sh800000;
            clip_c = 1'b1;
        end
        else
            sat_l = sl[23:0];
        if (sr > SAT_HI)
        begin
            sat_r  = 24'sh7FFFFF;
            clip_c = 1'b1;
        end
        else if (sr < SAT_LO)
        begin
            sat_r  = 24'sh800000;
            clip_c = 1'b1;
        end
        else
            sat_r = sr[23:0];
        cext  = {9'b0, count_reg};
        act_c = (cext > (CNT_W+9)'(511)) ? 9'd511 : cext[8:0];
    end

    always_ff @(posedge clk)
    begin
        if (cmd.fin_mul)
        begin
            plo_l_reg <= accl_reg[19:0] * gain_reg;
            plo_r_reg <= accr_reg[19:0] * gain_reg;
            phi_l_reg <= (HI_W+17)'($signed(accl_reg[ACC_W-1:20]))
                         * (HI_W+17)'($signed({1'b0, gain_reg}));
            phi_r_reg <= (HI_W+17)'($signed(accr_reg[ACC_W-1:20]))
                         * (HI_W+17)'($signed({1'b0, gain_reg}));
        end
        if (cmd.fin_out)
        begin
            mix_l_reg <= sat_l;
            mix_r_reg <= sat_r;
            clip_reg  <= clip_c;
            act_reg   <= act_c;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (cmd.fin_out)
            out_valid_reg <= 1'b1;
        else if (out_ready)
            out_valid_reg <= 1'b0;
    end

    assign out_valid     = out_valid_reg;
    assign mix_left      = mix_l_reg;
    assign mix_right     = mix_r_reg;
    assign clipped       = clip_reg;
    assign active_grains = act_reg;

    assign stat.cnt_zero    = (cnt_eff == '0);
    assign stat.slot_active = active_reg[g_reg];
    assign stat.last_slot   = (g_reg == LAST_SLOT);
    assign stat.grain_done  = (slot_rd_reg.offset >= slot_rd_reg.len);
    assign stat.out_range   = oor_reg;
    assign stat.div_done    = (dcnt_reg == '0);
    assign stat.out_free    = !out_valid_reg || out_ready;

endmodule

### rtl/ggm_ctrl.sv
module ggm_ctrl (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    input  logic [1:0]         in_command,
    input  ggm_pkg::dp_stat_t  stat,
    output logic               in_ready,
    output ggm_pkg::ctl_cmd_t  cmd
);

    typedef enum logic [14:0] {
        S_IDLE  = 15'b000000000000001,
        S_SPAWN = 15'b000000000000010,
        S_TRD   = 15'b000000000000100,
        S_TCHK  = 15'b000000000001000,
        S_TIDX  = 15'b000000000010000,
        S_TRNG  = 15'b000000000100000,
        S_TRD2  = 15'b000000001000000,
        S_TINT  = 15'b000000010000000,
        S_TAMP  = 15'b000000100000000,
        S_TWIN  = 15'b000001000000000,
        S_TMW   = 15'b000010000000000,
        S_TPAN  = 15'b000100000000000,
        S_TACC  = 15'b001000000000000,
        S_FIN1  = 15'b010000000000000,
        S_FIN2  = 15'b100000000000000
    } state_t;

    state_t state_reg, state_next;
    logic   accept;

    assign in_ready = (state_reg == S_IDLE);
    assign accept   = in_valid && in_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= S_IDLE;
        else
            state_reg <= state_next;
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        cmd.accept = accept;
        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    if (in_command == ggm_pkg::CMD_SPAWN && !stat.cnt_zero)
                    begin
                        cmd.slot_clr = 1'b1;
                        state_next   = S_SPAWN;
                    end
                    else if (in_command == ggm_pkg::CMD_TICK)
                    begin
                        cmd.slot_clr = 1'b1;
                        cmd.acc_clr  = 1'b1;
                        state_next   = stat.cnt_zero ? S_FIN1 : S_TRD;
                    end
                end
            end
            S_SPAWN:
            begin
                if (!stat.slot_active)
                begin
                    cmd.spawn_wr = 1'b1;
                    state_next   = S_IDLE;
                end
                else if (stat.last_slot)
                    state_next = S_IDLE;
                else
                    cmd.slot_inc = 1'b1;
            end
            S_TRD:
            begin
                if (stat.slot_active)
                begin
                    cmd.slot_rd = 1'b1;
                    state_next  = S_TCHK;
                end
                else if (stat.last_slot)
                    state_next = S_FIN1;
                else
                    cmd.slot_inc = 1'b1;
            end
            S_TCHK:
            begin
                if (stat.grain_done)
                begin
                    cmd.grain_end = 1'b1;
                    if (stat.last_slot)
                        state_next = S_FIN1;
                    else
                    begin
                        cmd.slot_inc = 1'b1;
                        state_next   = S_TRD;
                    end
                end
                else
                begin
                    cmd.calc_prod = 1'b1;
                    state_next    = S_TIDX;
                end
            end
            S_TIDX:
            begin
                cmd.calc_idx = 1'b1;
                state_next   = S_TRNG;
            end
            S_TRNG:
            begin
                if (stat.out_range)
                begin
                    cmd.grain_end = 1'b1;
                    if (stat.last_slot)
                        state_next = S_FIN1;
                    else
                    begin
                        cmd.slot_inc = 1'b1;
                        state_next   = S_TRD;
                    end
                end
                else
                begin
                    cmd.st_rd1    = 1'b1;
                    cmd.div_start = 1'b1;
                    state_next    = S_TRD2;
                end
            end
            S_TRD2:
            begin
                cmd.st_rd2 = 1'b1;
                state_next = S_TINT;
            end
            S_TINT:
            begin
                cmd.interp = 1'b1;
                state_next = S_TAMP;
            end
            S_TAMP:
            begin
                cmd.amp_mul = 1'b1;
                state_next  = S_TWIN;
            end
            S_TWIN:
            begin
                if (stat.div_done)
                begin
                    cmd.rom_rd = 1'b1;
                    state_next = S_TMW;
                end
            end
            S_TMW:
            begin
                cmd.win_mul = 1'b1;
                state_next  = S_TPAN;
            end
            S_TPAN:
            begin
                cmd.pan_mul = 1'b1;
                state_next  = S_TACC;
            end
            S_TACC:
            begin
                cmd.acc_wb = 1'b1;
                if (stat.last_slot)
                    state_next = S_FIN1;
                else
                begin
                    cmd.slot_inc = 1'b1;
                    state_next   = S_TRD;
                end
            end
            S_FIN1:
            begin
                cmd.fin_mul = 1'b1;
                state_next  = S_FIN2;
            end
            S_FIN2:
            begin
                if (stat.out_free)
                begin
                    cmd.fin_out = 1'b1;
                    state_next  = S_IDLE;
                end
            end
            default:
                state_next = S_IDLE;
        endcase
    end

endmodule

### rtl/granular_grain_mixer.sv
// Granular grain mixer. Words on item are load (write one stereo word to the
// sample store), spawn (start a grain in the lowest free slot) or tick (mix
// one output frame, answered by one word on result). A spawn scans the slots
// one per cycle. Unless the sample count is zero, a tick walks every slot
// through one shared datapath; an active grain's time is set by the
// window-index divider and the sample store read twice per grain through
// its one read port, and the output gain and saturation follow the walk.
// No input word is taken while a spawn or tick is in progress; a finished
// result waits in its output register without holding up the next input
// word.
module granular_grain_mixer #(
    parameter int GRAIN_SLOTS = 256,
    parameter int STORE_DEPTH = 65536
) (
    input  logic                        clk,
    input  logic                        rst_n,
    ggm_item_if.sink                    item,
    ggm_result_if.source                result,
    input  logic                        cfg_we,
    input  logic [1:0]                  cfg_index,
    input  logic [ggm_pkg::CFG_W-1:0]   cfg_data
);

    ggm_pkg::ctl_cmd_t cmd;
    ggm_pkg::dp_stat_t stat;
    logic              in_ready;

    assign item.ready = in_ready;

    ggm_ctrl u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (item.valid),
        .in_command (item.command),
        .stat       (stat),
        .in_ready   (in_ready),
        .cmd        (cmd)
    );

    ggm_datapath #(
        .GRAIN_SLOTS (GRAIN_SLOTS),
        .STORE_DEPTH (STORE_DEPTH)
    ) u_dp (
        .clk             (clk),
        .rst_n           (rst_n),
        .cmd             (cmd),
        .stat            (stat),
        .command         (item.command),
        .sample_address  (item.sample_address),
        .sample_left     (item.sample_left),
        .sample_right    (item.sample_right),
        .grain_start     (item.grain_start),
        .grain_length    (item.grain_length),
        .grain_pitch     (item.grain_pitch),
        .grain_reverse   (item.grain_reverse),
        .grain_amplitude (item.grain_amplitude),
        .pan_left_gain   (item.pan_left_gain),
        .pan_right_gain  (item.pan_right_gain),
        .cfg_we          (cfg_we),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data),
        .out_valid       (result.valid),
        .out_ready       (result.ready),
        .mix_left        (result.mix_left),
        .mix_right       (result.mix_right),
        .clipped         (result.clipped),
        .active_grains   (result.active_grains)
    );

endmodule

### rtl/ggm_checker.sv
`include "assert_macros.svh"

module ggm_checker #(
    parameter int GRAIN_SLOTS = 256
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               res_valid,
    input  logic               res_ready,
    input  logic signed [23:0] mix_left,
    input  logic signed [23:0] mix_right,
    input  logic               clipped,
    input  logic [8:0]         active_grains
);

    localparam logic [8:0] CNT_MAX = (GRAIN_SLOTS > 511) ? 9'd511 : 9'(GRAIN_SLOTS);

    `GGM_ASSERT(a_res_hold, res_valid && !res_ready |=> res_valid && $stable(mix_left) && $stable(mix_right) && $stable(clipped) && $stable(active_grains), "result word changed while stalled")

    // a clipped frame must sit on a rail in at least one channel
    `GGM_ASSERT(a_clip_rail, res_valid && clipped |-> mix_left == 24'sh7FFFFF || mix_left == 24'sh800000 || mix_right == 24'sh7FFFFF || mix_right == 24'sh800000, "clip flag without a saturated channel")

    `GGM_ASSERT_NEVER(a_count_max, res_valid && (active_grains > CNT_MAX), "active grain count beyond slot count")

endmodule

bind granular_grain_mixer ggm_checker #(
    .GRAIN_SLOTS (GRAIN_SLOTS)
) u_ggm_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .res_valid     (result.valid),
    .res_ready     (result.ready),
    .mix_left      (result.mix_left),
    .mix_right     (result.mix_right),
    .clipped       (result.clipped),
    .active_grains (result.active_grains)
);
